### rtl/see_pkg.sv
// Shared types and codes for the stack expression evaluator.
// No dependencies; used by every module of the block.
package see_pkg;

    localparam int STACK_WORDS_DEF = 256;

    localparam logic [2:0] OP_PUSH = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_SUB  = 3'd2;
    localparam logic [2:0] OP_MUL  = 3'd3;
    localparam logic [2:0] OP_DIV  = 3'd4;
    localparam logic [2:0] OP_REM  = 3'd5;
    localparam logic [2:0] OP_NEG  = 3'd6;
    localparam logic [2:0] OP_FUNC = 3'd7;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_OVERFLOW  = 3'd1;
    localparam logic [2:0] ST_UNDERFLOW = 3'd2;
    localparam logic [2:0] ST_DIVZERO   = 3'd3;
    localparam logic [2:0] ST_INVALID   = 3'd4;
    localparam logic [2:0] ST_DEPTH     = 3'd5;

    typedef struct packed {
        logic [2:0]  operation;
        logic        number_type;
        logic [31:0] push_value;
        logic        end_of_program;
    } t_in_beat;

    typedef struct packed {
        logic [31:0] result_word;
        logic [2:0]  status;
    } t_out_beat;

    typedef struct packed {
        logic        start;
        logic [2:0]  op;
        logic        is_float;
        logic [31:0] a;
        logic [31:0] b;
    } t_alu_req;

    typedef struct packed {
        logic        done;
        logic        div_zero;
        logic [31:0] result;
    } t_alu_rsp;

endpackage

### rtl/see_stack.sv
// Stack word storage: one write port, one registered read port.
// Depends on see_pkg for the default depth.
module see_stack #(
    parameter int STACK_WORDS = see_pkg::STACK_WORDS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic [$clog2(STACK_WORDS)-1:0] i_waddr,
    input  logic [31:0]                    i_wdata,
    input  logic [$clog2(STACK_WORDS)-1:0] i_raddr,
    output logic [31:0]                    o_rdata
);
    logic [31:0] r_mem [STACK_WORDS];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/see_alu.sv
// Shared multi-cycle arithmetic unit: integer add, sub, mul, div, rem and IEEE single add, sub, mul, div.
// One multiplier, one restoring divider and a bit-serial normalizer. Depends on see_pkg.
module see_alu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  see_pkg::t_alu_req i_req,
    output see_pkg::t_alu_rsp o_rsp
);
    import see_pkg::*;

    localparam int EW = 11;
    localparam int MW = 28;
    localparam logic signed [EW-1:0] E_ONE  = 11'sd1;
    localparam logic signed [EW-1:0] E_LOW  = -11'sd27;
    localparam logic signed [EW-1:0] E_BIAS = 11'sd127;
    localparam logic signed [EW-1:0] E_MAX  = 11'sd255;
    localparam logic signed [EW-1:0] E_SH   = 11'sd28;
    localparam logic [31:0] F_QNAN = 32'h7FC0_0000;
    localparam logic [30:0] F_INF  = 31'h7F80_0000;

    typedef enum logic [8:0] {
        A_IDLE    = 9'b000000001,
        A_PRENORM = 9'b000000010,
        A_ALIGN   = 9'b000000100,
        A_MUL     = 9'b000001000,
        A_MULRES  = 9'b000010000,
        A_DIV     = 9'b000100000,
        A_DIVRES  = 9'b001000000,
        A_NORM    = 9'b010000000,
        A_ROUND   = 9'b100000000
    } t_astate;

    t_astate r_state, n_state;
    logic [2:0]  r_op, n_op;
    logic        r_flt, n_flt;
    logic        r_sa, n_sa, r_sb, n_sb, r_sgn, n_sgn;
    logic signed [EW-1:0] r_ea, n_ea, r_eb, n_eb, r_exp, n_exp;
    logic [23:0] r_ma, n_ma, r_mb, n_mb;
    logic [31:0] r_rem, n_rem, r_num, n_num, r_den, n_den, r_quo, n_quo;
    logic [5:0]  r_cnt, n_cnt;
    logic [47:0] r_prod, n_prod;
    logic [MW-1:0] r_man, n_man;
    logic [31:0] r_res, n_res;
    logic        r_done, n_done, r_dz, n_dz;

    // operand unpack
    logic [7:0]  fe_a, fe_b;
    logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b, sb_eff, s_x;
    logic        sp_hit;
    logic [31:0] sp_word;

    assign fe_a   = i_req.a[30:23];
    assign fe_b   = i_req.b[30:23];
    assign nan_a  = (fe_a == 8'hFF) && (i_req.a[22:0] != 23'd0);
    assign nan_b  = (fe_b == 8'hFF) && (i_req.b[22:0] != 23'd0);
    assign inf_a  = (fe_a == 8'hFF) && (i_req.a[22:0] == 23'd0);
    assign inf_b  = (fe_b == 8'hFF) && (i_req.b[22:0] == 23'd0);
    assign zero_a = (i_req.a[30:0] == 31'd0);
    assign zero_b = (i_req.b[30:0] == 31'd0);
    assign sb_eff = i_req.b[31] ^ (i_req.op == OP_SUB);
    assign s_x    = i_req.a[31] ^ i_req.b[31];

    always_comb begin
        sp_hit  = 1'b1;
        sp_word = F_QNAN;
        case (i_req.op)
            OP_ADD, OP_SUB: begin
                if (nan_a || nan_b) begin
                    sp_word = F_QNAN;
                end else if (inf_a && inf_b) begin
                    sp_word = (i_req.a[31] == sb_eff) ? {i_req.a[31], F_INF} : F_QNAN;
                end else if (inf_a) begin
                    sp_word = {i_req.a[31], F_INF};
                end else if (inf_b) begin
                    sp_word = {sb_eff, F_INF};
                end else if (zero_a && zero_b) begin
                    sp_word = {i_req.a[31] & sb_eff, 31'd0};
                end else if (zero_a) begin
                    sp_word = {sb_eff, i_req.b[30:0]};
                end else if (zero_b) begin
                    sp_word = i_req.a;
                end else begin
                    sp_hit = 1'b0;
                end
            end
            OP_MUL: begin
                if (nan_a || nan_b || (inf_a && zero_b) || (zero_a && inf_b)) begin
                    sp_word = F_QNAN;
                end else if (inf_a || inf_b) begin
                    sp_word = {s_x, F_INF};
                end else if (zero_a || zero_b) begin
                    sp_word = {s_x, 31'd0};
                end else begin
                    sp_hit = 1'b0;
                end
            end
            default: begin
                if (nan_a || nan_b || (inf_a && inf_b) || (zero_a && zero_b)) begin
                    sp_word = F_QNAN;
                end else if (inf_a || zero_b) begin
                    sp_word = {s_x, F_INF};
                end else if (inf_b || zero_a) begin
                    sp_word = {s_x, 31'd0};
                end else begin
                    sp_hit = 1'b0;
                end
            end
        endcase
    end

    // alignment adder
    logic              a_big;
    logic signed [EW-1:0] e_hi, e_lo, e_diff;
    logic [23:0]       m_hi, m_lo;
    logic [4:0]        sh;
    logic [MW-1:0]     big_m, lo_full, lo_al, sum;
    logic              lo_st;

    assign a_big   = (r_ea > r_eb) || ((r_ea == r_eb) && (r_ma >= r_mb));
    assign e_hi    = a_big ? r_ea : r_eb;
    assign e_lo    = a_big ? r_eb : r_ea;
    assign m_hi    = a_big ? r_ma : r_mb;
    assign m_lo    = a_big ? r_mb : r_ma;
    assign e_diff  = e_hi - e_lo;
    assign sh      = (e_diff > E_SH) ? 5'd28 : e_diff[4:0];
    assign big_m   = {1'b0, m_hi, 3'b000};
    assign lo_full = {1'b0, m_lo, 3'b000};
    assign lo_st   = |(lo_full & ~({MW{1'b1}} << sh));
    assign lo_al   = (lo_full >> sh) | {{(MW-1){1'b0}}, lo_st};
    assign sum     = (r_sa == r_sb) ? big_m + lo_al : big_m - lo_al;

    // multiplier
    logic [31:0] mul_x, mul_y;
    logic [63:0] mul_full;

    assign mul_x    = r_flt ? {8'd0, r_ma} : r_num;
    assign mul_y    = r_flt ? {8'd0, r_mb} : r_den;
    assign mul_full = mul_x * mul_y;

    // divider step
    logic [32:0] d_t;
    logic [32:0] d_sub;
    logic        d_ge;

    assign d_t   = {r_rem, r_num[31]};
    assign d_sub = d_t - {1'b0, r_den};
    assign d_ge  = (d_t >= {1'b0, r_den});

    // rounding
    logic        rnd_inc;
    logic [24:0] rnd_m;
    logic [23:0] m_fin;
    logic signed [EW-1:0] e_fin;

    assign rnd_inc = r_man[2] & (r_man[1] | r_man[0] | r_man[3]);
    assign rnd_m   = {1'b0, r_man[26:3]} + {24'd0, rnd_inc};
    assign m_fin   = rnd_m[24] ? rnd_m[24:1] : rnd_m[23:0];
    assign e_fin   = r_exp + {{(EW-1){1'b0}}, rnd_m[24]};

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_flt   = r_flt;
        n_sa    = r_sa;
        n_sb    = r_sb;
        n_sgn   = r_sgn;
        n_ea    = r_ea;
        n_eb    = r_eb;
        n_exp   = r_exp;
        n_ma    = r_ma;
        n_mb    = r_mb;
        n_rem   = r_rem;
        n_num   = r_num;
        n_den   = r_den;
        n_quo   = r_quo;
        n_cnt   = r_cnt;
        n_prod  = r_prod;
        n_man   = r_man;
        n_res   = r_res;
        n_done  = 1'b0;
        n_dz    = r_dz;
        case (r_state)
            A_IDLE: begin
                if (i_req.start) begin
                    n_op  = i_req.op;
                    n_flt = i_req.is_float;
                    n_dz  = 1'b0;
                    if (i_req.is_float) begin
                        n_sa  = i_req.a[31];
                        n_sb  = sb_eff;
                        n_sgn = s_x;
                        n_ea  = (fe_a == 8'd0) ? E_ONE : $signed({3'b000, fe_a});
                        n_eb  = (fe_b == 8'd0) ? E_ONE : $signed({3'b000, fe_b});
                        n_ma  = {fe_a != 8'd0, i_req.a[22:0]};
                        n_mb  = {fe_b != 8'd0, i_req.b[22:0]};
                        if (sp_hit) begin
                            n_res  = sp_word;
                            n_done = 1'b1;
                        end else begin
                            n_state = A_PRENORM;
                        end
                    end else begin
                        case (i_req.op)
                            OP_ADD: begin
                                n_res  = i_req.a + i_req.b;
                                n_done = 1'b1;
                            end
                            OP_SUB: begin
                                n_res  = i_req.a - i_req.b;
                                n_done = 1'b1;
                            end
                            OP_MUL: begin
                                n_num   = i_req.a;
                                n_den   = i_req.b;
                                n_state = A_MUL;
                            end
                            OP_DIV, OP_REM: begin
                                if (i_req.b == 32'd0) begin
                                    n_res  = 32'd0;
                                    n_dz   = 1'b1;
                                    n_done = 1'b1;
                                end else begin
                                    n_sa    = i_req.a[31];
                                    n_sb    = i_req.b[31];
                                    n_num   = i_req.a[31] ? 32'd0 - i_req.a : i_req.a;
                                    n_den   = i_req.b[31] ? 32'd0 - i_req.b : i_req.b;
                                    n_rem   = 32'd0;
                                    n_cnt   = 6'd32;
                                    n_state = A_DIV;
                                end
                            end
                            default: begin
                                n_res  = 32'd0;
                                n_done = 1'b1;
                            end
                        endcase
                    end
                end
            end
            A_PRENORM: begin
                if (r_ma[23] && r_mb[23]) begin
                    case (r_op)
                        OP_ADD, OP_SUB: begin
                            n_state = A_ALIGN;
                        end
                        OP_MUL: begin
                            n_exp   = r_ea + r_eb - E_BIAS;
                            n_state = A_MUL;
                        end
                        default: begin
                            n_exp   = r_ea - r_eb + E_BIAS;
                            n_rem   = {9'd0, r_ma[23:1]};
                            n_num   = {r_ma[0], 31'd0};
                            n_den   = {8'd0, r_mb};
                            n_cnt   = 6'd27;
                            n_state = A_DIV;
                        end
                    endcase
                end else begin
                    if (!r_ma[23]) begin
                        n_ma = {r_ma[22:0], 1'b0};
                        n_ea = r_ea - E_ONE;
                    end
                    if (!r_mb[23]) begin
                        n_mb = {r_mb[22:0], 1'b0};
                        n_eb = r_eb - E_ONE;
                    end
                end
            end
            A_ALIGN: begin
                if (sum == {MW{1'b0}}) begin
                    n_res   = 32'd0;
                    n_done  = 1'b1;
                    n_state = A_IDLE;
                end else begin
                    n_man   = sum;
                    n_exp   = e_hi;
                    n_sgn   = a_big ? r_sa : r_sb;
                    n_state = A_NORM;
                end
            end
            A_MUL: begin
                n_prod  = mul_full[47:0];
                n_state = A_MULRES;
            end
            A_MULRES: begin
                if (r_flt) begin
                    n_man   = {r_prod[47:21], |r_prod[20:0]};
                    n_state = A_NORM;
                end else begin
                    n_res   = r_prod[31:0];
                    n_done  = 1'b1;
                    n_state = A_IDLE;
                end
            end
            A_DIV: begin
                n_rem = d_ge ? d_sub[31:0] : d_t[31:0];
                n_num = {r_num[30:0], 1'b0};
                n_quo = {r_quo[30:0], d_ge};
                n_cnt = r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    n_state = A_DIVRES;
                end
            end
            A_DIVRES: begin
                if (r_flt) begin
                    n_man   = {1'b0, r_quo[26:1], r_quo[0] | (r_rem != 32'd0)};
                    n_state = A_NORM;
                end else begin
                    if (r_op == OP_REM) begin
                        n_res = r_sa ? 32'd0 - r_rem : r_rem;
                    end else begin
                        n_res = (r_sa ^ r_sb) ? 32'd0 - r_quo : r_quo;
                    end
                    n_done  = 1'b1;
                    n_state = A_IDLE;
                end
            end
            A_NORM: begin
                if (r_man[27]) begin
                    n_man = {1'b0, r_man[27:2], r_man[1] | r_man[0]};
                    n_exp = r_exp + E_ONE;
                end else if (r_exp <= E_LOW) begin
                    n_man = {{(MW-1){1'b0}}, 1'b1};
                    n_exp = E_ONE;
                end else if (r_exp < E_ONE) begin
                    n_man = {1'b0, r_man[27:2], r_man[1] | r_man[0]};
                    n_exp = r_exp + E_ONE;
                end else if (!r_man[26] && (r_exp > E_ONE)) begin
                    n_man = {r_man[26:0], 1'b0};
                    n_exp = r_exp - E_ONE;
                end else begin
                    n_state = A_ROUND;
                end
            end
            A_ROUND: begin
                if (e_fin >= E_MAX) begin
                    n_res = {r_sgn, F_INF};
                end else begin
                    n_res = {r_sgn, m_fin[23] ? e_fin[7:0] : 8'd0, m_fin[22:0]};
                end
                n_done  = 1'b1;
                n_state = A_IDLE;
            end
            default: begin
                n_state = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_flt  <= n_flt;
        r_sa   <= n_sa;
        r_sb   <= n_sb;
        r_sgn  <= n_sgn;
        r_ea   <= n_ea;
        r_eb   <= n_eb;
        r_exp  <= n_exp;
        r_ma   <= n_ma;
        r_mb   <= n_mb;
        r_rem  <= n_rem;
        r_num  <= n_num;
        r_den  <= n_den;
        r_quo  <= n_quo;
        r_cnt  <= n_cnt;
        r_prod <= n_prod;
        r_man  <= n_man;
        r_res  <= n_res;
        r_dz   <= n_dz;
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.div_zero = r_dz;
    assign o_rsp.result   = r_res;

endmodule

### rtl/stack_expression_evaluator.sv
// Stack expression evaluator top level: operation sequencer, stack storage and shared ALU.
// Depends on see_pkg, see_stack and see_alu.
//
// One operation beat is taken at a time; o_ready is high only between operations. Integer
// div and rem run through the divider, which yields one quotient bit per cycle. Float ops
// add operand normalization for subnormal inputs, a divider pass for div and a bit-serial
// result normalization. The end-of-program beat adds a bottom-word read before the result
// beat is loaded into the output register, which lets the next operation be accepted while
// the result still waits. An end-of-program beat that finds an earlier result still waiting
// holds in the bottom-word read until that result is taken.
module stack_expression_evaluator #(
    parameter int STACK_WORDS = see_pkg::STACK_WORDS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  see_pkg::t_in_beat i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output see_pkg::t_out_beat o_data
);
    import see_pkg::*;

    localparam int AW = $clog2(STACK_WORDS);
    localparam int DW = $clog2(STACK_WORDS + 1);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b00000001,
        S_DECODE = 8'b00000010,
        S_RDB    = 8'b00000100,
        S_RDA    = 8'b00001000,
        S_EXEC   = 8'b00010000,
        S_FIN    = 8'b00100000,
        S_RDBOT  = 8'b01000000,
        S_OUT    = 8'b10000000
    } t_state;

    t_state      r_state, n_state;
    t_in_beat    r_beat, n_beat;
    logic [DW-1:0] r_depth, n_depth;
    logic [2:0]  r_err, n_err;
    logic [31:0] r_b, n_b;
    logic        r_out_valid, n_out_valid;
    t_out_beat   r_out, n_out;

    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [31:0]   mem_wdata, mem_rdata;
    t_alu_req      alu_req;
    t_alu_rsp      alu_rsp;
    logic [DW-1:0] depth_m1, depth_m2;

    assign depth_m1 = r_depth - DW'(1);
    assign depth_m2 = r_depth - DW'(2);

    function automatic logic [2:0] f_flag(input logic [2:0] cur, input logic [2:0] code);
        return (cur == ST_OK) ? code : cur;
    endfunction

    see_stack #(.STACK_WORDS(STACK_WORDS)) u_stack (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    see_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .o_rsp   (alu_rsp)
    );

    always_comb begin
        n_state     = r_state;
        n_beat      = r_beat;
        n_depth     = r_depth;
        n_err       = r_err;
        n_b         = r_b;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = 32'd0;
        mem_raddr   = '0;
        alu_req.start    = 1'b0;
        alu_req.op       = r_beat.operation;
        alu_req.is_float = r_beat.number_type;
        alu_req.a        = mem_rdata;
        alu_req.b        = r_b;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_beat  = i_data;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_FIN;
                if ((r_beat.operation == OP_FUNC) ||
                    ((r_beat.operation == OP_REM) && r_beat.number_type)) begin
                    n_err = f_flag(r_err, ST_INVALID);
                end else if (r_beat.operation == OP_PUSH) begin
                    if (r_depth >= DW'(STACK_WORDS)) begin
                        n_err = f_flag(r_err, ST_OVERFLOW);
                    end else begin
                        mem_we    = 1'b1;
                        mem_waddr = r_depth[AW-1:0];
                        mem_wdata = r_beat.push_value;
                        n_depth   = r_depth + DW'(1);
                    end
                end else if (r_beat.operation == OP_NEG) begin
                    if (r_depth < DW'(1)) begin
                        n_err = f_flag(r_err, ST_UNDERFLOW);
                    end else begin
                        mem_raddr = depth_m1[AW-1:0];
                        n_state   = S_RDB;
                    end
                end else begin
                    if (r_depth < DW'(2)) begin
                        n_err = f_flag(r_err, ST_UNDERFLOW);
                    end else begin
                        mem_raddr = depth_m1[AW-1:0];
                        n_state   = S_RDB;
                    end
                end
            end
            S_RDB: begin
                if (r_beat.operation == OP_NEG) begin
                    mem_we    = 1'b1;
                    mem_waddr = depth_m1[AW-1:0];
                    mem_wdata = r_beat.number_type ? {~mem_rdata[31], mem_rdata[30:0]}
                                                   : 32'd0 - mem_rdata;
                    n_state   = S_FIN;
                end else begin
                    n_b       = mem_rdata;
                    mem_raddr = depth_m2[AW-1:0];
                    n_state   = S_RDA;
                end
            end
            S_RDA: begin
                alu_req.start = 1'b1;
                n_state       = S_EXEC;
            end
            S_EXEC: begin
                if (alu_rsp.done) begin
                    mem_we    = 1'b1;
                    mem_waddr = depth_m2[AW-1:0];
                    mem_wdata = alu_rsp.result;
                    n_depth   = depth_m1;
                    if (alu_rsp.div_zero) begin
                        n_err = f_flag(r_err, ST_DIVZERO);
                    end
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_state = r_beat.end_of_program ? S_RDBOT : S_IDLE;
            end
            S_RDBOT: begin
                if (!r_out_valid || i_ready) begin
                    n_out.result_word = (r_depth >= DW'(1)) ? mem_rdata : 32'd0;
                    n_out.status      = ((r_err == ST_OK) && (r_depth != DW'(1))) ? ST_DEPTH
                                                                                  : r_err;
                    n_depth           = '0;
                    n_err             = ST_OK;
                    n_state           = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_depth     <= '0;
            r_err       <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_depth     <= n_depth;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_beat <= n_beat;
        r_b    <= n_b;
        r_out  <= n_out;
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

### test/tb_top.sv
// Self-checking testbench for stack_expression_evaluator: random-gap driver and monitor,
// with an in-bench stack machine that predicts each end-of-program result beat.
// Depends on see_pkg and the stack_expression_evaluator RTL.
`timescale 1ns / 100ps

module tb_top;
    import see_pkg::*;

    localparam int DEPTH_MAX = STACK_WORDS_DEF;
    localparam logic [31:0] QNAN = 32'h7FC00000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_ready;
    t_in_beat  i_data = '0;
    logic      o_valid;
    logic      i_ready = 1'b0;
    t_out_beat o_data;

    stack_expression_evaluator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_data),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    t_in_beat  op_queue[$];
    t_out_beat result_queue[$];
    logic [31:0] stk[DEPTH_MAX];
    int        stk_depth = 0;
    logic [2:0] err_code = ST_OK;
    int        errors = 0;
    int        beats_sent = 0;
    logic      long_stall = 1'b0;

    task automatic report(input string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    function automatic int pick_gap();
        if ($urandom_range(9) == 0) return $urandom_range(60, 20);
        return $urandom_range(3, 1);
    endfunction

    function automatic real word_to_real(input logic [31:0] w);
        logic [7:0]  e;
        logic [23:0] m;
        int          ex;
        e = w[30:23];
        m = {1'b0, w[22:0]};
        if (e == 8'hFF) return $bitstoreal({w[31], 11'h7FF, w[22:0], 29'b0});
        if (e == 0) begin
            if (m == 0) return $bitstoreal({w[31], 63'b0});
            ex = -126;
            while (!m[23]) begin
                m = m << 1;
                ex--;
            end
            return $bitstoreal({w[31], 11'(ex + 1023), m[22:0], 29'b0});
        end
        return $bitstoreal({w[31], 11'(int'(e) - 127 + 1023), w[22:0], 29'b0});
    endfunction

    function automatic logic [31:0] real_to_word(input real r);
        logic [63:0] d, sig, kept, rem, half;
        logic        s;
        int          e, shift;
        d = $realtobits(r);
        s = d[63];
        if (d[62:52] == 11'h7FF) return (d[51:0] != 0) ? QNAN : {s, 8'hFF, 23'b0};
        if (d[62:52] == 0) return {s, 31'b0};
        e = int'(d[62:52]) - 1023;
        sig = {11'b0, 1'b1, d[51:0]};
        shift = (e >= -126) ? 29 : 29 + (-126 - e);
        if (shift > 54) return {s, 31'b0};
        kept = sig >> shift;
        rem = sig & ((64'd1 << shift) - 1);
        half = 64'd1 << (shift - 1);
        if (rem > half || (rem == half && kept[0])) kept++;
        if (e >= -126) begin
            if (kept[24]) begin
                kept = kept >> 1;
                e++;
            end
            if (e > 127) return {s, 8'hFF, 23'b0};
            return {s, 8'(e + 127), kept[22:0]};
        end
        return {s, kept[23] ? 8'd1 : 8'd0, kept[22:0]};
    endfunction

    function automatic logic is_nan(input logic [31:0] w);
        return w[30:23] == 8'hFF && w[22:0] != 0;
    endfunction

    function automatic logic [31:0] float_arith(input logic [2:0] op, input logic [31:0] a,
                                                input logic [31:0] b);
        real ra, rb, rr;
        if (is_nan(a) || is_nan(b)) return QNAN;
        if (op == OP_DIV && b[30:0] == 0)
            return (a[30:0] == 0) ? QNAN : {a[31] ^ b[31], 8'hFF, 23'b0};
        ra = word_to_real(a);
        rb = word_to_real(b);
        case (op)
            OP_ADD:  rr = ra + rb;
            OP_SUB:  rr = ra - rb;
            OP_MUL:  rr = ra * rb;
            default: rr = ra / rb;
        endcase
        return real_to_word(rr);
    endfunction

    function automatic void latch_err(input logic [2:0] code);
        if (err_code == ST_OK) err_code = code;
    endfunction

    function automatic logic [31:0] int_divide(input logic [31:0] a, input logic [31:0] b,
                                               input logic want_rem);
        logic [31:0] ua, ub, q, r;
        if (b == 0) begin
            latch_err(ST_DIVZERO);
            return 32'd0;
        end
        ua = a[31] ? -a : a;
        ub = b[31] ? -b : b;
        q = ua / ub;
        r = ua % ub;
        if (a[31] != b[31]) q = -q;
        if (a[31]) r = -r;
        return want_rem ? r : q;
    endfunction

    function automatic void eval_beat(input t_in_beat bt);
        logic [31:0] a, b, v;
        t_out_beat   res;
        if (bt.operation == OP_PUSH) begin
            if (stk_depth >= DEPTH_MAX) latch_err(ST_OVERFLOW);
            else stk[stk_depth++] = bt.push_value;
        end else if (bt.operation == OP_FUNC || (bt.operation == OP_REM && bt.number_type)) begin
            latch_err(ST_INVALID);
        end else if (bt.operation == OP_NEG) begin
            if (stk_depth < 1) latch_err(ST_UNDERFLOW);
            else begin
                v = stk[stk_depth - 1];
                stk[stk_depth - 1] = bt.number_type ? (v ^ 32'h80000000) : -v;
            end
        end else if (stk_depth < 2) begin
            latch_err(ST_UNDERFLOW);
        end else begin
            b = stk[stk_depth - 1];
            a = stk[stk_depth - 2];
            if (bt.number_type) v = float_arith(bt.operation, a, b);
            else case (bt.operation)
                OP_ADD:  v = a + b;
                OP_SUB:  v = a - b;
                OP_MUL:  v = a * b;
                OP_DIV:  v = int_divide(a, b, 1'b0);
                default: v = int_divide(a, b, 1'b1);
            endcase
            stk[stk_depth - 2] = v;
            stk_depth--;
        end
        if (bt.end_of_program) begin
            res.status = err_code;
            if (res.status == ST_OK && stk_depth != 1) res.status = ST_DEPTH;
            res.result_word = (stk_depth >= 1) ? stk[0] : 32'd0;
            result_queue.push_back(res);
            stk_depth = 0;
            err_code = ST_OK;
        end
    endfunction

    // driver
    int drv_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                eval_beat(i_data);
                beats_sent++;
            end
            if (!i_valid || o_ready) begin
                if (drv_gap > 0) begin
                    drv_gap--;
                    i_valid <= 1'b0;
                end else if (op_queue.size() > 0) begin
                    i_data <= op_queue.pop_front();
                    i_valid <= 1'b1;
                    if ($urandom_range(3) == 0) drv_gap = pick_gap();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    int mon_gap = 0;
    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (result_queue.size() == 0) begin
                    report($sformatf("unexpected result beat %h/%0d",
                                     o_data.result_word, o_data.status));
                end else begin
                    want = result_queue.pop_front();
                    if (o_data.result_word !== want.result_word)
                        report($sformatf("result_word %h, want %h",
                                         o_data.result_word, want.result_word));
                    if (o_data.status !== want.status)
                        report($sformatf("status %0d, want %0d", o_data.status, want.status));
                end
            end
            if (long_stall || mon_gap > 0) begin
                if (mon_gap > 0) mon_gap--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                if ($urandom_range(3) == 0) mon_gap = pick_gap();
            end
        end
    end

    task automatic put(input logic [2:0] op, input logic ft, input logic [31:0] v,
                       input logic last);
        t_in_beat bt;
        bt.operation = op;
        bt.number_type = ft;
        bt.push_value = v;
        bt.end_of_program = last;
        op_queue.push_back(bt);
    endtask

    function automatic logic [31:0] rand_word(input logic ft);
        logic [31:0] ints[6] = '{32'h0, 32'h1, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h2};
        logic [31:0] flts[8] = '{32'h0, 32'h80000000, 32'h3F800000, 32'h7F7FFFFF,
                                 32'h00000001, 32'h7F800000, 32'hFF800000, 32'h7FC00001};
        case ($urandom_range(3))
            0: return ft ? flts[$urandom_range(7)] : ints[$urandom_range(5)];
            1: return $urandom_range(20) - 10;
            2: return ft ? {1'($urandom_range(1)), 8'($urandom_range(140, 110)), 23'($urandom)}
                         : $urandom;
            default: return $urandom;
        endcase
    endfunction

    task automatic gen_program();
        int   d, n, k;
        logic ft;
        logic [2:0] op;
        ft = $urandom_range(1);
        n = $urandom_range(7, 1);
        d = 0;
        k = 0;
        if ($urandom_range(9) == 0) begin
            n = $urandom_range(5, 1);
            for (int i = 0; i < n; i++)
                put(3'($urandom_range(7)), 1'($urandom_range(1)), $urandom, i == n - 1);
        end else begin
            while (k < n || d != 1) begin
                if (d < 2 && !(d == 1 && k >= n) || (k < n && $urandom_range(2) == 0)) begin
                    put(OP_PUSH, ft, rand_word(ft), 1'b0);
                    d++;
                    k++;
                end else if ($urandom_range(5) == 0) begin
                    put(OP_NEG, ft, $urandom, 1'b0);
                end else begin
                    op = 3'($urandom_range(ft ? 4 : 5, 1));
                    put(op, ft, $urandom, 1'b0);
                    d--;
                end
            end
            if ($urandom_range(7) == 0) put(3'($urandom_range(7)), ft, $urandom, 1'b0);
            op_queue[op_queue.size() - 1].end_of_program = 1'b1;
        end
    endtask

    initial begin
        // directed corners: quotient and remainder, underflow, invalid ops, float specials and depth
        put(OP_PUSH, 0, 32'h80000000, 0); put(OP_PUSH, 0, 32'hFFFFFFFF, 0); put(OP_DIV, 0, 0, 1);
        put(OP_PUSH, 0, 32'hFFFFFFF9, 0); put(OP_PUSH, 0, 32'h2, 0); put(OP_REM, 0, 0, 1);
        put(OP_PUSH, 0, 32'h5, 0); put(OP_PUSH, 0, 32'h0, 0); put(OP_REM, 0, 0, 1);
        put(OP_ADD, 0, 0, 1);
        put(OP_FUNC, 1, 32'hFFFFFFFF, 1);
        put(OP_PUSH, 1, 32'h3F800000, 0); put(OP_PUSH, 1, 32'h0, 0); put(OP_REM, 1, 0, 1);
        put(OP_PUSH, 1, 32'h3F800000, 0); put(OP_PUSH, 1, 32'h80000000, 0); put(OP_DIV, 1, 0, 1);
        put(OP_PUSH, 1, 32'h0, 0); put(OP_PUSH, 1, 32'h0, 0); put(OP_DIV, 1, 0, 0);
        put(OP_NEG, 1, 0, 1);
        put(OP_PUSH, 1, 32'h7F7FFFFF, 0); put(OP_PUSH, 1, 32'h7F7FFFFF, 0); put(OP_MUL, 1, 0, 1);
        put(OP_PUSH, 0, 32'h1, 0); put(OP_PUSH, 0, 32'h2, 1);
        put(OP_NEG, 0, 0, 1);
        // overflow: one push past the full stack
        for (int i = 0; i <= DEPTH_MAX; i++) put(OP_PUSH, 0, $urandom, i == DEPTH_MAX);
        while (op_queue.size() < 700) gen_program();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        wait (beats_sent > 500);
        @(posedge i_clk);
        long_stall <= 1'b1;
        repeat (3000) @(posedge i_clk);
        long_stall <= 1'b0;
    end

    initial begin
        wait (i_rst_n);
        wait (op_queue.size() == 0 && !i_valid);
        wait (result_queue.size() == 0);
        repeat (200) @(posedge i_clk);
        if (errors == 0 && result_queue.size() == 0) begin
            $display("== PASS ==");
        end else begin
            if (result_queue.size() != 0) report("results still expected at end");
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #1000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

### filelist.f
rtl/see_pkg.sv
rtl/see_stack.sv
rtl/see_alu.sv
rtl/stack_expression_evaluator.sv
test/tb_top.sv
